// ===== rtl/hoi_pkg.sv =====
// Shared types, constants and the microprogram of the harmonic oscillator integrator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hoi_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 24;
    localparam int DT_FRAC   = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ADDR_W    = 7;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_SQ = 2'd3;

    localparam logic [MODE_W-1:0] MODE_EULER      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS_VERLET = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [DT_W-1:0]  DT_RESET       = 24'd167772;
    localparam logic [CFG_W-1:0] INV_DT_RESET   = 32'd6553600;
    localparam logic [CFG_W-1:0] OMEGA_SQ_RESET = 32'd65536;

    typedef struct packed {
        logic               op;
        logic signed [31:0] init_position;
        logic signed [31:0] init_velocity;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
    } res_item_t;

    typedef enum logic [2:0] {
        U_NOP,
        U_MUL,
        U_MFIN,
        U_ADD,
        U_SUB
    } uop_t;

    typedef enum logic [3:0] {
        SRC_X,
        SRC_V,
        SRC_P,
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_D,
        SRC_IX,
        SRC_IV,
        SRC_OMEGA,
        SRC_DT,
        SRC_INV_DT,
        SRC_ZERO
    } src_t;

    typedef enum logic [2:0] {
        DST_X,
        DST_V,
        DST_P,
        DST_A,
        DST_B,
        DST_C,
        DST_D
    } dst_t;

    typedef enum logic [1:0] {
        SH_FRAC,
        SH_DT,
        SH_HALF_DT
    } shift_t;

    typedef enum logic [2:0] {
        FL_NEXT,
        FL_END,
        FL_JUMP,
        FL_JSTEP,
        FL_JPV,
        FL_JMODE
    } flow_t;

    typedef logic [ADDR_W-1:0] uaddr_t;

    typedef struct packed {
        uop_t   uop;
        src_t   src_a;
        src_t   src_b;
        dst_t   dst;
        shift_t shift;
        flow_t  flow;
        uaddr_t target;
    } ucw_t;

    localparam uaddr_t A_ENTRY    = 7'd0;
    localparam uaddr_t A_LDPV     = 7'd4;
    localparam uaddr_t A_STEP     = 7'd23;
    localparam uaddr_t A_MODE_TBL = 7'd24;
    localparam uaddr_t A_EU       = 7'd28;
    localparam uaddr_t A_SE       = 7'd39;
    localparam uaddr_t A_VV       = 7'd49;
    localparam uaddr_t A_PV       = 7'd68;

    function automatic ucw_t f_ctl(flow_t f, uaddr_t t);
        ucw_t w;
        w = '{uop: U_NOP, src_a: SRC_ZERO, src_b: SRC_ZERO, dst: DST_A,
              shift: SH_FRAC, flow: f, target: t};
        return w;
    endfunction

    function automatic ucw_t f_mul(src_t a, src_t b, shift_t s);
        ucw_t w;
        w = '{uop: U_MUL, src_a: a, src_b: b, dst: DST_A,
              shift: s, flow: FL_NEXT, target: A_ENTRY};
        return w;
    endfunction

    function automatic ucw_t f_fin(dst_t d);
        ucw_t w;
        w = '{uop: U_MFIN, src_a: SRC_ZERO, src_b: SRC_ZERO, dst: d,
              shift: SH_FRAC, flow: FL_NEXT, target: A_ENTRY};
        return w;
    endfunction

    function automatic ucw_t f_add(dst_t d, src_t a, src_t b);
        ucw_t w;
        w = '{uop: U_ADD, src_a: a, src_b: b, dst: d,
              shift: SH_FRAC, flow: FL_NEXT, target: A_ENTRY};
        return w;
    endfunction

    function automatic ucw_t f_sub(dst_t d, src_t a, src_t b);
        ucw_t w;
        w = '{uop: U_SUB, src_a: a, src_b: b, dst: d,
              shift: SH_FRAC, flow: FL_NEXT, target: A_ENTRY};
        return w;
    endfunction

    function automatic ucw_t f_end(ucw_t w_in);
        ucw_t w;
        w      = w_in;
        w.flow = FL_END;
        return w;
    endfunction

    // Each product takes two steps: the multiply, then the shift, rounding and saturation.
    function automatic ucw_t ucode_rom(uaddr_t addr);
        ucw_t w;
        case (addr)
            7'd0:  w = f_ctl(FL_JSTEP, A_STEP);
            7'd1:  begin
                       w        = f_add(DST_P, SRC_IX, SRC_ZERO);
                       w.flow   = FL_JPV;
                       w.target = A_LDPV;
                   end
            7'd2:  w = f_add(DST_X, SRC_IX, SRC_ZERO);
            7'd3:  w = f_end(f_add(DST_V, SRC_IV, SRC_ZERO));
            // Load in position Verlet: Taylor step to x1, then velocity recovery.
            7'd4:  w = f_mul(SRC_IV, SRC_DT, SH_DT);
            7'd5:  w = f_fin(DST_B);
            7'd6:  w = f_add(DST_B, SRC_IX, SRC_B);
            7'd7:  w = f_mul(SRC_OMEGA, SRC_IX, SH_FRAC);
            7'd8:  w = f_fin(DST_A);
            7'd9:  w = f_sub(DST_A, SRC_ZERO, SRC_A);
            7'd10: w = f_mul(SRC_DT, SRC_DT, SH_HALF_DT);
            7'd11: w = f_fin(DST_C);
            7'd12: w = f_mul(SRC_A, SRC_C, SH_DT);
            7'd13: w = f_fin(DST_A);
            7'd14: w = f_add(DST_X, SRC_B, SRC_A);
            7'd15: w = f_sub(DST_A, SRC_X, SRC_IX);
            7'd16: w = f_mul(SRC_A, SRC_INV_DT, SH_FRAC);
            7'd17: w = f_fin(DST_A);
            7'd18: w = f_mul(SRC_OMEGA, SRC_X, SH_FRAC);
            7'd19: w = f_fin(DST_B);
            7'd20: w = f_mul(SRC_B, SRC_DT, SH_HALF_DT);
            7'd21: w = f_fin(DST_B);
            7'd22: w = f_end(f_sub(DST_V, SRC_A, SRC_B));
            // Step dispatch on the integrator mode.
            7'd23: w = f_ctl(FL_JMODE, A_MODE_TBL);
            7'd24: w = f_ctl(FL_JUMP, A_EU);
            7'd25: w = f_ctl(FL_JUMP, A_SE);
            7'd26: w = f_ctl(FL_JUMP, A_VV);
            7'd27: w = f_ctl(FL_JUMP, A_PV);
            // Explicit Euler.
            7'd28: w = f_mul(SRC_V, SRC_DT, SH_DT);
            7'd29: w = f_fin(DST_B);
            7'd30: w = f_add(DST_B, SRC_X, SRC_B);
            7'd31: w = f_mul(SRC_OMEGA, SRC_X, SH_FRAC);
            7'd32: w = f_fin(DST_A);
            7'd33: w = f_sub(DST_A, SRC_ZERO, SRC_A);
            7'd34: w = f_mul(SRC_A, SRC_DT, SH_DT);
            7'd35: w = f_fin(DST_A);
            7'd36: w = f_add(DST_V, SRC_V, SRC_A);
            7'd37: w = f_add(DST_P, SRC_X, SRC_ZERO);
            7'd38: w = f_end(f_add(DST_X, SRC_B, SRC_ZERO));
            // Symplectic Euler, velocity first.
            7'd39: w = f_mul(SRC_OMEGA, SRC_X, SH_FRAC);
            7'd40: w = f_fin(DST_A);
            7'd41: w = f_sub(DST_A, SRC_ZERO, SRC_A);
            7'd42: w = f_mul(SRC_A, SRC_DT, SH_DT);
            7'd43: w = f_fin(DST_A);
            7'd44: w = f_add(DST_V, SRC_V, SRC_A);
            7'd45: w = f_mul(SRC_V, SRC_DT, SH_DT);
            7'd46: w = f_fin(DST_B);
            7'd47: w = f_add(DST_P, SRC_X, SRC_ZERO);
            7'd48: w = f_end(f_add(DST_X, SRC_X, SRC_B));
            // Velocity Verlet.
            7'd49: w = f_mul(SRC_V, SRC_DT, SH_DT);
            7'd50: w = f_fin(DST_B);
            7'd51: w = f_add(DST_B, SRC_X, SRC_B);
            7'd52: w = f_mul(SRC_OMEGA, SRC_X, SH_FRAC);
            7'd53: w = f_fin(DST_A);
            7'd54: w = f_sub(DST_A, SRC_ZERO, SRC_A);
            7'd55: w = f_mul(SRC_DT, SRC_DT, SH_HALF_DT);
            7'd56: w = f_fin(DST_C);
            7'd57: w = f_mul(SRC_A, SRC_C, SH_DT);
            7'd58: w = f_fin(DST_A);
            7'd59: w = f_add(DST_D, SRC_B, SRC_A);
            7'd60: w = f_add(DST_A, SRC_X, SRC_D);
            7'd61: w = f_mul(SRC_OMEGA, SRC_A, SH_FRAC);
            7'd62: w = f_fin(DST_A);
            7'd63: w = f_mul(SRC_A, SRC_DT, SH_HALF_DT);
            7'd64: w = f_fin(DST_A);
            7'd65: w = f_sub(DST_V, SRC_V, SRC_A);
            7'd66: w = f_add(DST_P, SRC_X, SRC_ZERO);
            7'd67: w = f_end(f_add(DST_X, SRC_D, SRC_ZERO));
            // Position Verlet.
            7'd68: w = f_mul(SRC_DT, SRC_DT, SH_DT);
            7'd69: w = f_fin(DST_C);
            7'd70: w = f_mul(SRC_OMEGA, SRC_X, SH_FRAC);
            7'd71: w = f_fin(DST_A);
            7'd72: w = f_mul(SRC_A, SRC_C, SH_DT);
            7'd73: w = f_fin(DST_A);
            7'd74: w = f_add(DST_B, SRC_X, SRC_X);
            7'd75: w = f_sub(DST_B, SRC_B, SRC_P);
            7'd76: w = f_sub(DST_D, SRC_B, SRC_A);
            7'd77: w = f_sub(DST_A, SRC_D, SRC_X);
            7'd78: w = f_mul(SRC_A, SRC_INV_DT, SH_FRAC);
            7'd79: w = f_fin(DST_A);
            7'd80: w = f_mul(SRC_OMEGA, SRC_D, SH_FRAC);
            7'd81: w = f_fin(DST_B);
            7'd82: w = f_mul(SRC_B, SRC_DT, SH_HALF_DT);
            7'd83: w = f_fin(DST_B);
            7'd84: w = f_sub(DST_V, SRC_A, SRC_B);
            7'd85: w = f_add(DST_P, SRC_X, SRC_ZERO);
            7'd86: w = f_end(f_add(DST_X, SRC_D, SRC_ZERO));
            default: w = f_ctl(FL_END, A_ENTRY);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hoi_mul.sv =====
// Shared fixed-point multiplier: one product registered, then truncation and saturation.
// Depends on hoi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hoi_mul (
    input  wire logic                                 clk,
    input  wire logic                                 issue,
    input  wire logic signed [hoi_pkg::OPND_W-1:0]    a,
    input  wire logic signed [hoi_pkg::OPND_W-1:0]    b,
    input  wire hoi_pkg::shift_t                      shift,
    output logic signed [hoi_pkg::DATA_W-1:0]         result
);

    localparam int DW = hoi_pkg::DATA_W;
    localparam int OW = hoi_pkg::OPND_W;
    localparam int PW = hoi_pkg::PROD_W;
    localparam logic [PW-1:0] POS_LIMIT = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [PW-1:0] NEG_LIMIT = {{(PW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    logic [PW-1:0]       prod_reg;
    logic [PW-1:0]       prod_next;
    logic                neg_reg;
    logic                neg_next;
    hoi_pkg::shift_t     shift_reg;
    hoi_pkg::shift_t     shift_next;
    logic signed [OW-1:0] abs_a;
    logic signed [OW-1:0] abs_b;
    logic [PW-1:0]       quo;
    logic [PW-1:0]       quo_rnd;
    logic                rem_nz;

    always_comb
    begin
        abs_a      = a[OW-1] ? -a : a;
        abs_b      = b[OW-1] ? -b : b;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        shift_next = shift_reg;
        if (issue)
        begin
            prod_next  = abs_a[DW-1:0] * abs_b[DW-1:0];
            neg_next   = a[OW-1] ^ b[OW-1];
            shift_next = shift;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        shift_reg <= shift_next;
    end

    always_comb
    begin
        case (shift_reg)
            hoi_pkg::SH_DT:
            begin
                quo    = prod_reg >> hoi_pkg::DT_FRAC;
                rem_nz = |prod_reg[hoi_pkg::DT_FRAC-1:0];
            end
            hoi_pkg::SH_HALF_DT:
            begin
                quo    = prod_reg >> (hoi_pkg::DT_FRAC + 1);
                rem_nz = |prod_reg[hoi_pkg::DT_FRAC:0];
            end
            default:
            begin
                quo    = prod_reg >> hoi_pkg::FRAC_BITS;
                rem_nz = |prod_reg[hoi_pkg::FRAC_BITS-1:0];
            end
        endcase
        quo_rnd = quo + {{(PW-1){1'b0}}, rem_nz};
        if (!neg_reg)
        begin
            result = (quo > POS_LIMIT) ? hoi_pkg::DATA_MAX : quo[DW-1:0];
        end
        else
        begin
            result = (quo_rnd > NEG_LIMIT) ? hoi_pkg::DATA_MIN : -quo_rnd[DW-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hoi_datapath.sv =====
// Datapath of the integrator: state and scratch registers, saturating adder, multiplier.
// Depends on hoi_pkg and hoi_mul; driven by the control word of hoi_seq.
`timescale 1ns / 1ps
`default_nettype none

module hoi_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hoi_pkg::ucw_t                       cw,
    input  wire logic                                capture,
    input  wire hoi_pkg::cmd_item_t                  cmd,
    input  wire logic [hoi_pkg::DT_W-1:0]            dt,
    input  wire logic [hoi_pkg::CFG_W-1:0]           inv_dt,
    input  wire logic [hoi_pkg::CFG_W-1:0]           omega_sq,
    output logic signed [hoi_pkg::DATA_W-1:0]        position,
    output logic signed [hoi_pkg::DATA_W-1:0]        velocity
);

    localparam int DW = hoi_pkg::DATA_W;
    localparam int OW = hoi_pkg::OPND_W;

    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] v_reg, v_next;
    logic signed [DW-1:0] p_reg, p_next;
    logic signed [DW-1:0] a_reg, a_next;
    logic signed [DW-1:0] b_reg, b_next;
    logic signed [DW-1:0] c_reg, c_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic signed [DW-1:0] ix_reg, ix_next;
    logic signed [DW-1:0] iv_reg, iv_next;

    logic signed [OW-1:0] opnd_a;
    logic signed [OW-1:0] opnd_b;
    logic signed [DW-1:0] alu_b;
    logic signed [DW-1:0] neg_b;
    logic signed [DW:0]   sum;
    logic signed [DW-1:0] alu_res;
    logic signed [DW-1:0] mul_res;
    logic signed [DW-1:0] wval;
    logic                 wen;

    always_comb
    begin
        case (cw.src_a)
            hoi_pkg::SRC_X:      opnd_a = {x_reg[DW-1], x_reg};
            hoi_pkg::SRC_V:      opnd_a = {v_reg[DW-1], v_reg};
            hoi_pkg::SRC_P:      opnd_a = {p_reg[DW-1], p_reg};
            hoi_pkg::SRC_A:      opnd_a = {a_reg[DW-1], a_reg};
            hoi_pkg::SRC_B:      opnd_a = {b_reg[DW-1], b_reg};
            hoi_pkg::SRC_C:      opnd_a = {c_reg[DW-1], c_reg};
            hoi_pkg::SRC_D:      opnd_a = {d_reg[DW-1], d_reg};
            hoi_pkg::SRC_IX:     opnd_a = {ix_reg[DW-1], ix_reg};
            hoi_pkg::SRC_IV:     opnd_a = {iv_reg[DW-1], iv_reg};
            hoi_pkg::SRC_OMEGA:  opnd_a = {1'b0, omega_sq};
            hoi_pkg::SRC_DT:     opnd_a = {{(OW-hoi_pkg::DT_W){1'b0}}, dt};
            hoi_pkg::SRC_INV_DT: opnd_a = {1'b0, inv_dt};
            default:             opnd_a = '0;
        endcase
        case (cw.src_b)
            hoi_pkg::SRC_X:      opnd_b = {x_reg[DW-1], x_reg};
            hoi_pkg::SRC_V:      opnd_b = {v_reg[DW-1], v_reg};
            hoi_pkg::SRC_P:      opnd_b = {p_reg[DW-1], p_reg};
            hoi_pkg::SRC_A:      opnd_b = {a_reg[DW-1], a_reg};
            hoi_pkg::SRC_B:      opnd_b = {b_reg[DW-1], b_reg};
            hoi_pkg::SRC_C:      opnd_b = {c_reg[DW-1], c_reg};
            hoi_pkg::SRC_D:      opnd_b = {d_reg[DW-1], d_reg};
            hoi_pkg::SRC_IX:     opnd_b = {ix_reg[DW-1], ix_reg};
            hoi_pkg::SRC_IV:     opnd_b = {iv_reg[DW-1], iv_reg};
            hoi_pkg::SRC_OMEGA:  opnd_b = {1'b0, omega_sq};
            hoi_pkg::SRC_DT:     opnd_b = {{(OW-hoi_pkg::DT_W){1'b0}}, dt};
            hoi_pkg::SRC_INV_DT: opnd_b = {1'b0, inv_dt};
            default:             opnd_b = '0;
        endcase
    end

    hoi_mul u_mul (
        .clk    (clk),
        .issue  (cw.uop == hoi_pkg::U_MUL),
        .a      (opnd_a),
        .b      (opnd_b),
        .shift  (cw.shift),
        .result (mul_res)
    );

    // Subtraction negates with saturation first, so the most negative value becomes the largest.
    always_comb
    begin
        neg_b   = (opnd_b[DW-1:0] == hoi_pkg::DATA_MIN) ? hoi_pkg::DATA_MAX : -opnd_b[DW-1:0];
        alu_b   = (cw.uop == hoi_pkg::U_SUB) ? neg_b : opnd_b[DW-1:0];
        sum     = {opnd_a[DW-1], opnd_a[DW-1:0]} + {alu_b[DW-1], alu_b};
        if (sum[DW] != sum[DW-1])
        begin
            alu_res = sum[DW] ? hoi_pkg::DATA_MIN : hoi_pkg::DATA_MAX;
        end
        else
        begin
            alu_res = sum[DW-1:0];
        end
        wen  = cw.uop inside {hoi_pkg::U_MFIN, hoi_pkg::U_ADD, hoi_pkg::U_SUB};
        wval = (cw.uop == hoi_pkg::U_MFIN) ? mul_res : alu_res;
    end

    always_comb
    begin
        x_next  = x_reg;
        v_next  = v_reg;
        p_next  = p_reg;
        a_next  = a_reg;
        b_next  = b_reg;
        c_next  = c_reg;
        d_next  = d_reg;
        ix_next = capture ? cmd.init_position : ix_reg;
        iv_next = capture ? cmd.init_velocity : iv_reg;
        if (wen)
        begin
            case (cw.dst)
                hoi_pkg::DST_X: x_next = wval;
                hoi_pkg::DST_V: v_next = wval;
                hoi_pkg::DST_P: p_next = wval;
                hoi_pkg::DST_A: a_next = wval;
                hoi_pkg::DST_B: b_next = wval;
                hoi_pkg::DST_C: c_next = wval;
                hoi_pkg::DST_D: d_next = wval;
                default:        a_next = a_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            v_reg <= '0;
            p_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            v_reg <= v_next;
            p_reg <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        c_reg  <= c_next;
        d_reg  <= d_next;
        ix_reg <= ix_next;
        iv_reg <= iv_next;
    end

    assign position = x_reg;
    assign velocity = v_reg;

endmodule

`default_nettype wire

// ===== rtl/hoi_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on hoi_pkg for the control word format and the microprogram.
`timescale 1ns / 1ps
`default_nettype none

module hoi_seq (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            op,
    input  wire logic [hoi_pkg::MODE_W-1:0]      mode,
    input  wire logic                            res_free,
    output logic                                 ready,
    output logic                                 res_load,
    output hoi_pkg::ucw_t                        cw
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } seq_state_t;

    localparam int AW = hoi_pkg::ADDR_W;

    seq_state_t        state_reg, state_next;
    hoi_pkg::uaddr_t   pc_reg, pc_next;
    logic              op_reg, op_next;
    hoi_pkg::ucw_t     rom_word;
    hoi_pkg::uaddr_t   pc_inc;

    always_comb
    begin
        rom_word   = hoi_pkg::ucode_rom(pc_reg);
        pc_inc     = pc_reg + {{(AW-1){1'b0}}, 1'b1};
        state_next = state_reg;
        pc_next    = pc_reg;
        op_next    = op_reg;
        res_load   = 1'b0;
        ready      = (state_reg == ST_IDLE);
        cw         = hoi_pkg::f_ctl(hoi_pkg::FL_NEXT, hoi_pkg::A_ENTRY);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    pc_next    = hoi_pkg::A_ENTRY;
                    op_next    = op;
                end
            end
            ST_RUN:
            begin
                cw = rom_word;
                case (rom_word.flow)
                    hoi_pkg::FL_END:
                    begin
                        state_next = ST_DONE;
                        pc_next    = hoi_pkg::A_ENTRY;
                    end
                    hoi_pkg::FL_JUMP:
                        pc_next = rom_word.target;
                    hoi_pkg::FL_JSTEP:
                        pc_next = (op_reg == hoi_pkg::OP_STEP) ? rom_word.target : pc_inc;
                    hoi_pkg::FL_JPV:
                        pc_next = (mode == hoi_pkg::MODE_POS_VERLET) ? rom_word.target : pc_inc;
                    hoi_pkg::FL_JMODE:
                        pc_next = rom_word.target + {{(AW-hoi_pkg::MODE_W){1'b0}}, mode};
                    default:
                        pc_next = pc_inc;
                endcase
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= hoi_pkg::A_ENTRY;
            op_reg    <= hoi_pkg::OP_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            op_reg    <= op_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/harmonic_oscillator_integrator.sv =====
// Top level of the harmonic oscillator integrator: configuration registers and result register.
// Depends on hoi_pkg, hoi_seq and hoi_datapath.
//
// Each transfer on the command channel either loads a position and velocity or advances the
// oscillator by one time step with the integrator chosen by the mode register, and gives one
// result transfer with the new position and velocity in signed Q16.16. Items are handled one at a
// time by a microprogram driving a single shared multiplier, two steps per product. The next
// command can be taken only once the result of the last one has gone into the output register,
// and it is taken while that result still waits there. Configuration is to be written only
// while the block is idle; the user must keep to this, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module harmonic_oscillator_integrator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cmd_valid,
    output logic                                    cmd_stall,
    input  wire hoi_pkg::cmd_item_t                 cmd,
    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output hoi_pkg::res_item_t                      res,
    input  wire logic                               cfg_we,
    input  wire logic [hoi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hoi_pkg::CFG_W-1:0]          cfg_data
);

    logic [hoi_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [hoi_pkg::DT_W-1:0]    dt_reg, dt_next;
    logic [hoi_pkg::CFG_W-1:0]   inv_dt_reg, inv_dt_next;
    logic [hoi_pkg::CFG_W-1:0]   omega_sq_reg, omega_sq_next;
    logic                        res_valid_reg, res_valid_next;
    hoi_pkg::res_item_t          res_reg, res_next;

    logic                        ready;
    logic                        start;
    logic                        res_load;
    logic                        res_free;
    hoi_pkg::ucw_t               cw;
    logic signed [hoi_pkg::DATA_W-1:0] position;
    logic signed [hoi_pkg::DATA_W-1:0] velocity;

    assign cmd_stall = !ready;
    assign start     = cmd_valid && ready;
    assign res_free  = !res_valid_reg || !res_stall;

    always_comb
    begin
        mode_next     = mode_reg;
        dt_next       = dt_reg;
        inv_dt_next   = inv_dt_reg;
        omega_sq_next = omega_sq_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                hoi_pkg::CFG_MODE:     mode_next     = cfg_data[hoi_pkg::MODE_W-1:0];
                hoi_pkg::CFG_DT:       dt_next       = cfg_data[hoi_pkg::DT_W-1:0];
                hoi_pkg::CFG_INV_DT:   inv_dt_next   = cfg_data;
                hoi_pkg::CFG_OMEGA_SQ: omega_sq_next = cfg_data;
                default:               mode_next     = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (res_load)
        begin
            res_valid_next    = 1'b1;
            res_next.position = position;
            res_next.velocity = velocity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= hoi_pkg::MODE_EULER;
            dt_reg        <= hoi_pkg::DT_RESET;
            inv_dt_reg    <= hoi_pkg::INV_DT_RESET;
            omega_sq_reg  <= hoi_pkg::OMEGA_SQ_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            dt_reg        <= dt_next;
            inv_dt_reg    <= inv_dt_next;
            omega_sq_reg  <= omega_sq_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    hoi_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (cmd.op),
        .mode     (mode_reg),
        .res_free (res_free),
        .ready    (ready),
        .res_load (res_load),
        .cw       (cw)
    );

    hoi_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cw       (cw),
        .capture  (start),
        .cmd      (cmd),
        .dt       (dt_reg),
        .inv_dt   (inv_dt_reg),
        .omega_sq (omega_sq_reg),
        .position (position),
        .velocity (velocity)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire
